>>> rtl/spm_pkg.sv
// Package for the sparse polynomial multiplier: widths, codes and record types.
`default_nettype none

package spm_pkg;

  // Store sizes
  localparam int MAX_TERMS   = 8;
  localparam int STORE_DEPTH = 8;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int PROD_DEPTH  = 64;
  localparam int PROD_AW     = $clog2(PROD_DEPTH);
  localparam int PCNT_W      = $clog2(PROD_DEPTH + 1);

  // Field widths
  localparam int COEF_IN_W   = 16;
  localparam int EXP_IN_W    = 8;
  localparam int COEF_OUT_W  = 38;
  localparam int EXP_OUT_W   = 9;
  localparam int PAIR_W      = 2 * COEF_IN_W;
  localparam int IDX_DEPTH   = 1 << EXP_OUT_W;
  localparam int KIND_W      = 2;

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_W   = ((COEF_IN_W + EXP_IN_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((COEF_OUT_W + EXP_OUT_W + 7) / 8) * 8;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_A   = 2'd0,
    KIND_LOAD_B   = 2'd1,
    KIND_MULTIPLY = 2'd2
  } kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_LOOK,
    ST_UPD,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_t;

  // One loaded term, coefficient in the low bits
  typedef struct packed {
    logic signed [EXP_IN_W-1:0]  exp;
    logic signed [COEF_IN_W-1:0] coef;
  } term_t;

  // One product term, coefficient in the low bits
  typedef struct packed {
    logic signed [EXP_OUT_W-1:0]  exp;
    logic signed [COEF_OUT_W-1:0] coef;
  } prod_t;

endpackage

`default_nettype wire

>>> rtl/sparse_polynomial_multiply.sv
// Sparse polynomial multiplier: term stores, product accumulation and term output.
//
// Input stream (in_*): each transfer carries a kind in in_tuser and a term in in_tdata.
// Kind load A / load B appends the term to store A or B (eight terms each; further
// terms are dropped). Kind multiply forms every pair product, A outer and B inner,
// merges products of equal exponent and then streams the product terms on out_* in
// order of first appearance, out_tlast on the final one. Both stores are empty
// afterwards; a multiply with no nonzero pair product sends nothing. Unused kinds
// are ignored.
// Each pair product goes through multiply and index-table read, product-store read
// and read-modify-write of the product store. A multiply holds the input through all
// pairs and the emission, which streams one term per cycle while out_tready is high.
// An exponent-indexed table of product slots finds the matching term in one read.
// After reset the block sweeps that 512-entry table with in_tready low. A stalled
// receiver holds the output register and the emission waits; the last term may
// wait in the output register while new input is already taken.
`default_nettype none

module sparse_polynomial_multiply (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  input  wire logic [spm_pkg::IN_DATA_W-1:0]  in_tdata,   // [15:0] coef_in, [23:16] exp_in
  input  wire logic [spm_pkg::KIND_W-1:0]     in_tuser,   // [1:0] kind
  output      logic                           out_tvalid,
  input  wire logic                           out_tready,
  output      logic [spm_pkg::OUT_DATA_W-1:0] out_tdata,  // [37:0] coef_out, [46:38] exp_out
  output      logic                           out_tlast   // last_term
);

  import spm_pkg::*;

  // Memories
  term_t                   a_mem   [STORE_DEPTH];
  term_t                   b_mem   [STORE_DEPTH];
  prod_t                   prod_mem[PROD_DEPTH];
  logic [PROD_AW-1:0]      idx_mem [IDX_DEPTH];

  // Registered read data
  term_t                   a_rd_r;
  term_t                   b_rd_r;
  prod_t                   prod_rd_r;
  logic [PROD_AW-1:0]      idx_rd_r;

  // Control state
  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        a_cnt_r, a_cnt_nxt;
  logic [CNT_W-1:0]        b_cnt_r, b_cnt_nxt;
  logic [PCNT_W-1:0]       pcnt_r, pcnt_nxt;
  logic [STORE_AW-1:0]     i_r, i_nxt;
  logic [STORE_AW-1:0]     j_r, j_nxt;
  logic [PCNT_W-1:0]       k_r, k_nxt;
  logic [EXP_OUT_W-1:0]    clr_r, clr_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Payload registers
  logic signed [PAIR_W-1:0]    p_r, p_nxt;
  logic signed [EXP_OUT_W-1:0] e_r, e_nxt;
  prod_t                       out_data_r;
  logic                        out_last_r;

  // Memory port controls
  logic                    a_we, b_we;
  logic                    prod_we;
  logic [PROD_AW-1:0]      prod_waddr, prod_raddr;
  prod_t                   prod_wdata;
  logic                    idx_we;
  logic [EXP_OUT_W-1:0]    idx_waddr, idx_raddr;
  logic [PROD_AW-1:0]      idx_wdata;
  logic                    out_load;
  logic                    hit;
  logic                    last_pair;
  term_t                   in_term;

  assign in_term = term_t'(in_tdata[COEF_IN_W+EXP_IN_W-1:0]);

  // Pair exponent and product from the current store reads
  assign e_nxt = EXP_OUT_W'(a_rd_r.exp) + EXP_OUT_W'(b_rd_r.exp);
  assign p_nxt = a_rd_r.coef * b_rd_r.coef;
  assign idx_raddr = e_nxt;

  // Slot from the index table is live only if below the fill count and tagged alike
  assign hit = ({1'b0, idx_rd_r} < pcnt_r) && (prod_rd_r.exp == e_r);
  assign last_pair = ((CNT_W'(j_r) + CNT_W'(1)) == b_cnt_r)
                  && ((CNT_W'(i_r) + CNT_W'(1)) == a_cnt_r);

  // Sequencer: next state and memory controls
  always_comb begin
    state_nxt   = state_r;
    a_cnt_nxt   = a_cnt_r;
    b_cnt_nxt   = b_cnt_r;
    pcnt_nxt    = pcnt_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    clr_nxt     = clr_r;
    in_tready   = 1'b0;
    a_we        = 1'b0;
    b_we        = 1'b0;
    prod_we     = 1'b0;
    prod_waddr  = idx_rd_r;
    prod_wdata  = prod_rd_r;
    prod_raddr  = idx_rd_r;
    idx_we      = 1'b0;
    idx_waddr   = e_r;
    idx_wdata   = pcnt_r[PROD_AW-1:0];
    out_load    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        idx_we    = 1'b1;
        idx_waddr = clr_r;
        idx_wdata = '0;
        clr_nxt   = clr_r + EXP_OUT_W'(1);
        if (clr_r == EXP_OUT_W'(IDX_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (in_tuser)
            KIND_LOAD_A: begin
              if (a_cnt_r < CNT_W'(MAX_TERMS)) begin
                a_we      = 1'b1;
                a_cnt_nxt = a_cnt_r + CNT_W'(1);
              end
            end
            KIND_LOAD_B: begin
              if (b_cnt_r < CNT_W'(MAX_TERMS)) begin
                b_we      = 1'b1;
                b_cnt_nxt = b_cnt_r + CNT_W'(1);
              end
            end
            KIND_MULTIPLY: begin
              pcnt_nxt = '0;
              i_nxt    = '0;
              j_nxt    = '0;
              if (a_cnt_r == '0 || b_cnt_r == '0) begin
                a_cnt_nxt = '0;
                b_cnt_nxt = '0;
              end else begin
                state_nxt = ST_MUL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MUL: begin
        state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        // Merge into the matching term or append a new one; zero products drop
        if (p_r != '0) begin
          prod_we = 1'b1;
          if (hit) begin
            prod_waddr      = idx_rd_r;
            prod_wdata.exp  = e_r;
            prod_wdata.coef = prod_rd_r.coef + COEF_OUT_W'(p_r);
          end else begin
            prod_waddr      = pcnt_r[PROD_AW-1:0];
            prod_wdata.exp  = e_r;
            prod_wdata.coef = COEF_OUT_W'(p_r);
            idx_we          = 1'b1;
            pcnt_nxt        = pcnt_r + PCNT_W'(1);
          end
        end
        // Advance the pair indices, B inner
        if (last_pair) begin
          i_nxt = '0;
          j_nxt = '0;
          k_nxt = '0;
          if (pcnt_nxt == '0) begin
            a_cnt_nxt = '0;
            b_cnt_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_EMIT_RD;
          end
        end else begin
          state_nxt = ST_MUL;
          if ((CNT_W'(j_r) + CNT_W'(1)) == b_cnt_r) begin
            j_nxt = '0;
            i_nxt = i_r + STORE_AW'(1);
          end else begin
            j_nxt = j_r + STORE_AW'(1);
          end
        end
      end
      ST_EMIT_RD: begin
        prod_raddr = k_r[PROD_AW-1:0];
        state_nxt  = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        // Load the output register when it is free or draining this cycle
        if (!out_valid_r || out_tready) begin
          out_load = 1'b1;
          k_nxt    = k_r + PCNT_W'(1);
          if (k_nxt == pcnt_r) begin
            a_cnt_nxt = '0;
            b_cnt_nxt = '0;
            pcnt_nxt  = '0;
            state_nxt = ST_IDLE;
          end
        end
        prod_raddr = k_nxt[PROD_AW-1:0];
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      a_cnt_r     <= '0;
      b_cnt_r     <= '0;
      pcnt_r      <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      a_cnt_r     <= a_cnt_nxt;
      b_cnt_r     <= b_cnt_nxt;
      pcnt_r      <= pcnt_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Pair product and exponent, held through lookup and update
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      p_r <= p_nxt;
      e_r <= e_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= prod_rd_r;
      out_last_r <= (k_nxt == pcnt_r);
    end
  end

  // Term stores: write on load, read at the next pair indices
  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[a_cnt_r[STORE_AW-1:0]] <= in_term;
    end
    if (b_we) begin
      b_mem[b_cnt_r[STORE_AW-1:0]] <= in_term;
    end
    a_rd_r <= a_mem[i_nxt];
    b_rd_r <= b_mem[j_nxt];
  end

  // Product store
  always_ff @(posedge clk) begin
    if (prod_we) begin
      prod_mem[prod_waddr] <= prod_wdata;
    end
    prod_rd_r <= prod_mem[prod_raddr];
  end

  // Exponent to slot index table
  always_ff @(posedge clk) begin
    if (idx_we) begin
      idx_mem[idx_waddr] <= idx_wdata;
    end
    idx_rd_r <= idx_mem[idx_raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);

endmodule

`default_nettype wire

>>> rtl/spm_checker.sv
// Port-level checks for the sparse polynomial multiplier, bound to the top level.
`default_nettype none

module spm_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic [spm_pkg::KIND_W-1:0]     in_tuser,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [spm_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                           out_tlast
);

  import spm_pkg::*;

  logic in_xfer;
  logic load_xfer;

  assign in_xfer   = in_tvalid && in_tready;
  assign load_xfer = in_xfer && (in_tuser == KIND_LOAD_A || in_tuser == KIND_LOAD_B);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // Input stays closed while a run is still being sent
  a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input open in the middle of a run");

  // Terms of a run follow one another without a gap
  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a run");

  // A load transfer never creates a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    load_xfer && !out_tvalid |=> !out_tvalid)
    else $error("result after a load");

endmodule

bind sparse_polynomial_multiply spm_checker u_spm_checker (.*);

`default_nettype wire

>>> bench/sparse_polynomial_multiply_tb.sv
// Self-checking testbench for the sparse polynomial multiplier stream block.
`timescale 1ns / 1ps

module sparse_polynomial_multiply_tb;
  import spm_pkg::*;

  localparam logic [KIND_W-1:0]             KIND_UNUSED = 2'd3;
  localparam logic signed [COEF_IN_W-1:0]   COEF_MAX    = 16'sh7fff;
  localparam logic signed [COEF_IN_W-1:0]   COEF_MIN    = 16'sh8000;
  localparam logic signed [EXP_IN_W-1:0]    EXP_MAX     = 8'sh7f;
  localparam logic signed [EXP_IN_W-1:0]    EXP_MIN     = 8'sh80;
  localparam int                            RANDOM_ITEMS = 250;
  localparam int                            TAIL_CYCLES  = 300;

  // One queued input transfer, or a pause marker that waits for all terms
  typedef struct {
    logic [KIND_W-1:0]            kind;
    logic signed [COEF_IN_W-1:0]  coef;
    logic signed [EXP_IN_W-1:0]   exp;
    bit                           pause;
  } stim_t;

  // One expected product term
  typedef struct {
    logic signed [COEF_OUT_W-1:0] coef;
    logic signed [EXP_OUT_W-1:0]  exp;
    logic                         last;
  } prod_term_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [KIND_W-1:0]     in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  stim_t      item_q [$];
  prod_term_t term_q [$];
  stim_t      cur_item;

  // Predicted state of the two term stores
  logic signed [COEF_IN_W-1:0] a_coef [MAX_TERMS];
  logic signed [EXP_IN_W-1:0]  a_exp  [MAX_TERMS];
  int                          a_cnt = 0;
  logic signed [COEF_IN_W-1:0] b_coef [MAX_TERMS];
  logic signed [EXP_IN_W-1:0]  b_exp  [MAX_TERMS];
  int                          b_cnt = 0;

  int n_errors      = 0;
  int n_queued      = 0;
  int items_sent    = 0;
  int n_multiplies  = 0;
  int terms_checked = 0;
  int taken         = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;

  sparse_polynomial_multiply dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    n_errors++;
  endtask

  // Apply one accepted transfer to the store copies; queue product terms on a multiply
  task automatic predict_item(input stim_t it);
    longint     acc_c [PROD_DEPTH];
    int         acc_e [PROD_DEPTH];
    int         n_acc;
    longint     p;
    int         e;
    bit         hit;
    prod_term_t t;
    case (it.kind)
      KIND_LOAD_A: begin
        if (a_cnt < MAX_TERMS) begin
          a_coef[a_cnt] = it.coef;
          a_exp[a_cnt]  = it.exp;
          a_cnt++;
        end
      end
      KIND_LOAD_B: begin
        if (b_cnt < MAX_TERMS) begin
          b_coef[b_cnt] = it.coef;
          b_exp[b_cnt]  = it.exp;
          b_cnt++;
        end
      end
      KIND_MULTIPLY: begin
        n_acc = 0;
        // A outer, B inner; merge equal exponents, skip zero products
        for (int i = 0; i < a_cnt; i++) begin
          for (int j = 0; j < b_cnt; j++) begin
            p = longint'(a_coef[i]) * longint'(b_coef[j]);
            if (p != 0) begin
              e   = int'(a_exp[i]) + int'(b_exp[j]);
              hit = 1'b0;
              for (int k = 0; k < n_acc && !hit; k++) begin
                if (acc_e[k] == e) begin
                  acc_c[k] += p;
                  hit = 1'b1;
                end
              end
              if (!hit) begin
                acc_c[n_acc] = p;
                acc_e[n_acc] = e;
                n_acc++;
              end
            end
          end
        end
        for (int k = 0; k < n_acc; k++) begin
          t.coef = acc_c[k][COEF_OUT_W-1:0];
          t.exp  = acc_e[k][EXP_OUT_W-1:0];
          t.last = (k == n_acc - 1);
          term_q.push_back(t);
        end
        a_cnt = 0;
        b_cnt = 0;
        n_multiplies++;
      end
      default: ;
    endcase
  endtask

  task automatic add_item(input logic [KIND_W-1:0] k, input logic signed [COEF_IN_W-1:0] c,
                          input logic signed [EXP_IN_W-1:0] e);
    stim_t s;
    s.kind  = k;
    s.coef  = c;
    s.exp   = e;
    s.pause = 1'b0;
    item_q.push_back(s);
    n_queued++;
  endtask

  task automatic add_pause();
    stim_t s;
    s.kind  = KIND_UNUSED;
    s.coef  = '0;
    s.exp   = '0;
    s.pause = 1'b1;
    item_q.push_back(s);
  endtask

  // Coefficients lean towards extremes, zero and small values that cancel
  function automatic logic signed [COEF_IN_W-1:0] rand_coef();
    case ($urandom_range(9))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      2:       return '0;
      3, 4, 5: return COEF_IN_W'(int'($urandom_range(6)) - 3);
      default: return COEF_IN_W'($urandom);
    endcase
  endfunction

  // Exponents lean towards a narrow band so that products collide
  function automatic logic signed [EXP_IN_W-1:0] rand_exp();
    case ($urandom_range(9))
      0:          return EXP_MAX;
      1:          return EXP_MIN;
      2, 3, 4, 5: return EXP_IN_W'(int'($urandom_range(4)) - 2);
      default:    return EXP_IN_W'($urandom);
    endcase
  endfunction

  // Mostly short polynomials, now and then a full or overfull store
  function automatic int term_count();
    if ($urandom_range(11) == 0) return $urandom_range(8, 9);
    return $urandom_range(4);
  endfunction

  // Offer queued transfers; hold each until taken, idle at random outside a calm stretch
  always @(posedge clk) begin : drive
    logic offer;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      offer = in_tvalid;
      if (in_tvalid && in_tready) begin
        predict_item(cur_item);
        items_sent <= items_sent + 1;
        offer = 1'b0;
      end
      if (!offer && item_q.size() != 0) begin
        if (item_q[0].pause) begin
          if (term_q.size() == 0) void'(item_q.pop_front());
        end else if ((items_sent >= 100 && items_sent < 160) || $urandom_range(99) >= 23) begin
          cur_item = item_q.pop_front();
          in_tdata <= {cur_item.exp, cur_item.coef};
          in_tuser <= cur_item.kind;
          offer = 1'b1;
        end
      end
      in_tvalid <= offer;
    end
  end

  // Drive out_tready: random stalls, a calm stretch and one long hold-off
  always @(posedge clk) begin : sink
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) taken++;
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && taken >= 120) begin
        hold_done = 1'b1;
        hold_left = 400;
        out_tready <= 1'b0;
      end else begin
        out_tready <= (taken >= 40 && taken < 100) || $urandom_range(99) >= 23;
      end
    end
  end

  // Check each output transfer against the oldest expected term
  always @(posedge clk) begin : watch
    prod_term_t               want;
    logic signed [COEF_OUT_W-1:0] got_c;
    logic signed [EXP_OUT_W-1:0]  got_e;
    if (rst_n && out_tvalid && out_tready) begin
      got_c = out_tdata[COEF_OUT_W-1:0];
      got_e = out_tdata[COEF_OUT_W +: EXP_OUT_W];
      if (term_q.size() == 0) begin
        report_mismatch($sformatf("unexpected term coef %0d exp %0d", got_c, got_e));
      end else begin
        want = term_q.pop_front();
        if (got_c !== want.coef)
          report_mismatch($sformatf("coef %0d, expected %0d", got_c, want.coef));
        if (got_e !== want.exp)
          report_mismatch($sformatf("exp %0d, expected %0d", got_e, want.exp));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last %b, expected %b", out_tlast, want.last));
      end
      terms_checked <= terms_checked + 1;
    end
  end

  // Build the stimulus, release reset and wait for the run to drain
  initial begin : stimulus
    int  roll;
    int  na;
    int  nb;
    int  n_directed;
    bit  midway_pause;
    midway_pause = 1'b0;

    // Multiply with both stores empty: nothing comes out
    add_item(KIND_MULTIPLY, '0, '0);
    // Fill both stores past capacity, extremes first; the ninth terms are dropped
    for (int i = 0; i < MAX_TERMS; i++)
      add_item(KIND_LOAD_A,
               COEF_IN_W'((i == 0) ? COEF_MAX : (i == 1) ? COEF_MIN : 1000 * i - 3500),
               EXP_IN_W'((i == 0) ? EXP_MAX : (i == 1) ? EXP_MIN : 20 * i - 70));
    add_item(KIND_LOAD_A, 11, 3);
    for (int j = 0; j < MAX_TERMS; j++)
      add_item(KIND_LOAD_B,
               COEF_IN_W'((j == 0) ? COEF_MIN : (j == 1) ? COEF_MAX : -77 * j),
               EXP_IN_W'((j == 0) ? EXP_MIN : (j == 1) ? EXP_MAX : 9 * j - 40));
    add_item(KIND_LOAD_B, 13, -5);
    add_item(KIND_MULTIPLY, '1, '1);
    // Cancellation to zero, a zero coefficient and an unused kind in between
    add_item(KIND_LOAD_A, 1, 1);
    add_item(KIND_UNUSED, COEF_MAX, 8'sd9);
    add_item(KIND_LOAD_A, 1, 0);
    add_item(KIND_LOAD_A, 0, 7);
    add_item(KIND_LOAD_B, 1, 0);
    add_item(KIND_LOAD_B, -1, 1);
    add_item(KIND_MULTIPLY, '0, '0);
    // All pair products zero: nothing comes out, stores still emptied
    add_item(KIND_LOAD_A, 0, 4);
    add_item(KIND_LOAD_B, 5, -3);
    add_item(KIND_MULTIPLY, '0, '0);
    add_pause();

    // Random part: mostly load runs ended by a multiply, some noise and stray loads
    n_directed = n_queued;
    while (n_queued - n_directed < RANDOM_ITEMS) begin
      if (!midway_pause && n_queued - n_directed >= RANDOM_ITEMS / 2) begin
        add_pause();
        midway_pause = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 6) begin
        add_item(KIND_UNUSED, COEF_IN_W'($urandom), EXP_IN_W'($urandom));
      end else if (roll < 12) begin
        repeat ($urandom_range(1, 3))
          add_item(KIND_W'($urandom_range(1)), rand_coef(), rand_exp());
      end else begin
        na = term_count();
        nb = term_count();
        while (na + nb != 0) begin
          if (nb == 0 || (na != 0 && $urandom_range(1) == 1)) begin
            add_item(KIND_LOAD_A, rand_coef(), rand_exp());
            na--;
          end else begin
            add_item(KIND_LOAD_B, rand_coef(), rand_exp());
            nb--;
          end
        end
        add_item(KIND_MULTIPLY, COEF_IN_W'($urandom), EXP_IN_W'($urandom));
      end
    end
    // Close with a multiply so no loaded terms are left behind
    add_item(KIND_MULTIPLY, '0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every transfer to be taken, then for every term, then let the block settle
    while (items_sent < n_queued) @(posedge clk);
    while (term_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d input transfers and %0d multiplies; %0d product terms checked.",
             items_sent, n_multiplies, terms_checked);
    $display("Directed extremes, full stores, cancellation and zero products, then random runs.");
    if (n_errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Guard against a hung run
  initial begin : watchdog
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/spm_pkg.sv
rtl/sparse_polynomial_multiply.sv
rtl/spm_checker.sv
bench/sparse_polynomial_multiply_tb.sv
